### sv/lsfe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED strip frame encoder package
// Item types, operation and register codes, palette and byte coding used
// by the encoder.
// ----------------------------------------------------------------------------
package lsfe_pkg;

	localparam logic [2:0] OP_WRITE_RGB   = 3'd0;
	localparam logic [2:0] OP_WRITE_COLOR = 3'd1;
	localparam logic [2:0] OP_CLEAR       = 3'd2;
	localparam logic [2:0] OP_START       = 3'd3;
	localparam logic [2:0] OP_TICK        = 3'd4;

	localparam logic [0:0] REG_COLOR_ORDER = 1'd0;
	localparam logic [0:0] REG_PIXEL_COUNT = 1'd1;

	localparam int CODED_BYTES_PER_PIXEL = 12;
	localparam logic [3:0] LAST_CODED_BYTE = 4'd11;

	localparam logic [3:0] NIBBLE_ONE  = 4'hC;
	localparam logic [3:0] NIBBLE_ZERO = 4'h8;

	localparam logic       COLOR_ORDER_RESET = 1'b1;
	localparam logic [8:0] PIXEL_COUNT_RESET = 9'd256;

	typedef struct packed {
		logic [2:0] operation;
		logic [7:0] pixel_index;
		logic [7:0] red_value;
		logic [7:0] green_value;
		logic [7:0] blue_value;
		logic [4:0] palette_code;
	} lsfe_cmd_t;

	typedef struct packed {
		logic [7:0] spi_byte;
		logic       last_byte;
	} lsfe_byte_t;

	// Fixed palette, stored as red, green, blue from the top byte down.
	function automatic logic [23:0] lsfe_palette(input logic [4:0] code);
		logic [23:0] rgb;
		unique case (code)
			5'd0:    rgb = 24'h000000;
			5'd1:    rgb = 24'hFFFFFF;
			5'd2:    rgb = 24'hFF0000;
			5'd3:    rgb = 24'h00FF00;
			5'd4:    rgb = 24'h0000FF;
			5'd5:    rgb = 24'h00FFFF;
			5'd6:    rgb = 24'hFF00FF;
			5'd7:    rgb = 24'hFFFF00;
			5'd8:    rgb = 24'h0000FF;
			5'd9:    rgb = 24'h008000;
			5'd10:   rgb = 24'h800000;
			5'd11:   rgb = 24'h808080;
			5'd12:   rgb = 24'h808000;
			5'd13:   rgb = 24'h800080;
			5'd14:   rgb = 24'hC0C0C0;
			5'd15:   rgb = 24'h008080;
			5'd16:   rgb = 24'hA52A2A;
			5'd17:   rgb = 24'hFFA500;
			5'd18:   rgb = 24'hFFD700;
			5'd19:   rgb = 24'hFF1493;
			default: rgb = 24'h000000;
		endcase
		return rgb;
	endfunction

	// One coded byte of a pixel: the upper two bits of k pick the channel,
	// the lower two bits pick the bit pair, most significant pair first.
	function automatic logic [7:0] lsfe_encode(input logic [23:0] word,
	                                           input logic [3:0] k,
	                                           input logic order);
		logic [7:0] ch;
		logic       hi;
		logic       lo;
		unique case (k[3:2])
			2'd0:    ch = order ? word[15:8] : word[23:16];
			2'd1:    ch = order ? word[23:16] : word[15:8];
			default: ch = word[7:0];
		endcase
		unique case (k[1:0])
			2'd0: begin
				hi = ch[7];
				lo = ch[6];
			end
			2'd1: begin
				hi = ch[5];
				lo = ch[4];
			end
			2'd2: begin
				hi = ch[3];
				lo = ch[2];
			end
			default: begin
				hi = ch[1];
				lo = ch[0];
			end
		endcase
		return {hi ? NIBBLE_ONE : NIBBLE_ZERO, lo ? NIBBLE_ONE : NIBBLE_ZERO};
	endfunction

endpackage

### sv/lsfe_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED strip frame encoder stream channel
// Valid/ready channel carrying one item of a given payload type.
// ----------------------------------------------------------------------------
interface lsfe_stream_if #(
	parameter type payload_t = logic [7:0]
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

### sv/lsfe_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED strip frame encoder RAM
// Simple dual-port memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module lsfe_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

### sv/led_strip_frame_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED strip frame encoder
// Holds the pixel store and turns it into a stream of coded SPI bytes.
// ----------------------------------------------------------------------------
//  channel   direction  carries
//  cmd       in         operation, pixel index, color, palette code
//  tx        out        one SPI byte and the last-byte flag
//  cfg_*     in         register writes: color order, pixel count
//
// A tick gives its byte in the output register in the cycle after it is taken.
// The pixel word sits in the RAM read register, which is refilled once per
// twelve coded bytes, so ticks can follow each other.
// Reset clears the pixel valid bits, so the store reads as zero right away.
// A command is taken whenever the output register is empty or being drained.
module led_strip_frame_encoder import lsfe_pkg::*; #(
	parameter int MAX_PIXELS = 256,
	parameter int BYTES_PER_PIXEL_SLOT = 32,
	localparam int ADDR_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1,
	localparam int CNT_W = $clog2(MAX_PIXELS * BYTES_PER_PIXEL_SLOT + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	lsfe_stream_if.sink          cmd,
	lsfe_stream_if.source        tx,
	input  logic                 cfg_we,
	input  logic [0:0]           cfg_index,
	input  logic [8:0]           cfg_data
);
	logic             color_order_q;
	logic [8:0]       pixel_count_q;
	logic [8:0]       eff_count;

	logic             active_q;
	logic [CNT_W-1:0] pos_q;
	logic [CNT_W-1:0] last_pos_q;
	logic [CNT_W-1:0] coded_len_q;
	logic [3:0]       k_q;
	logic [ADDR_W-1:0] pix_q;

	logic [MAX_PIXELS-1:0] valid_q;
	logic             rd_valid_s1;

	logic             out_valid_q;
	lsfe_byte_t       out_q;

	lsfe_cmd_t        c;
	logic             accept;
	logic             in_range;
	logic             do_write;
	logic             do_clear;
	logic             do_start;
	logic             do_tick;
	logic             is_last;

	logic             ram_re;
	logic [ADDR_W-1:0] ram_raddr;
	logic [23:0]      ram_wdata;
	logic [23:0]      ram_rdata;
	logic [23:0]      word;
	logic [7:0]       coded_byte;

	assign c = cmd.payload;
	assign eff_count = (pixel_count_q > 9'(MAX_PIXELS)) ? 9'(MAX_PIXELS) : pixel_count_q;
	assign cmd.ready = !out_valid_q || tx.ready;
	assign accept = cmd.valid && cmd.ready;
	assign in_range = {1'b0, c.pixel_index} < eff_count;

	always_comb begin
		do_write = 1'b0;
		do_clear = 1'b0;
		do_start = 1'b0;
		do_tick = 1'b0;
		ram_wdata = {c.red_value, c.green_value, c.blue_value};
		unique case (c.operation)
			OP_WRITE_RGB: begin
				do_write = accept && !active_q && in_range;
			end
			OP_WRITE_COLOR: begin
				do_write = accept && !active_q && in_range;
				ram_wdata = lsfe_palette(c.palette_code);
			end
			OP_CLEAR: begin
				do_clear = accept && !active_q;
			end
			OP_START: begin
				do_start = accept && !active_q && (eff_count != 9'd0);
			end
			OP_TICK: begin
				do_tick = accept && active_q;
			end
			default: begin
			end
		endcase
	end

	// The next pixel is fetched on the tick that finishes the current one.
	assign is_last = (pos_q == last_pos_q);
	assign ram_re = do_start || (do_tick && (k_q == LAST_CODED_BYTE));
	assign ram_raddr = do_start ? '0 : pix_q + ADDR_W'(1);

	lsfe_ram #(
		.WIDTH(24),
		.DEPTH(MAX_PIXELS)
	) u_pixel_ram (
		.clk   (clk),
		.we    (do_write),
		.waddr (c.pixel_index[ADDR_W-1:0]),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign word = rd_valid_s1 ? ram_rdata : 24'h000000;
	assign coded_byte = (pos_q < coded_len_q) ? lsfe_encode(word, k_q, color_order_q) : 8'h00;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			if (do_clear) begin
				valid_q <= '0;
			end else if (do_write) begin
				valid_q[c.pixel_index[ADDR_W-1:0]] <= 1'b1;
			end
			if (ram_re) begin
				rd_valid_s1 <= (int'(ram_raddr) < MAX_PIXELS) ? valid_q[ram_raddr] : 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_order_q <= COLOR_ORDER_RESET;
			pixel_count_q <= PIXEL_COUNT_RESET;
		end else if (cfg_we && !active_q) begin
			unique case (cfg_index)
				REG_COLOR_ORDER: color_order_q <= cfg_data[0];
				REG_PIXEL_COUNT: pixel_count_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			pos_q <= '0;
			k_q <= '0;
			pix_q <= '0;
		end else if (do_start) begin
			active_q <= 1'b1;
			pos_q <= '0;
			k_q <= '0;
			pix_q <= '0;
		end else if (do_tick) begin
			if (is_last) begin
				active_q <= 1'b0;
				pos_q <= '0;
			end else begin
				pos_q <= pos_q + CNT_W'(1);
			end
			if (k_q == LAST_CODED_BYTE) begin
				k_q <= '0;
				pix_q <= pix_q + ADDR_W'(1);
			end else begin
				k_q <= k_q + 4'd1;
			end
		end
	end

	// Frame lengths are fixed for the whole frame, so they are taken at start.
	always_ff @(posedge clk) begin
		if (do_start) begin
			coded_len_q <= CNT_W'(32'(eff_count) * CODED_BYTES_PER_PIXEL);
			last_pos_q <= CNT_W'(32'(eff_count) * BYTES_PER_PIXEL_SLOT - 1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (do_tick) begin
			out_valid_q <= 1'b1;
		end else if (tx.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_tick) begin
			out_q.spi_byte <= coded_byte;
			out_q.last_byte <= is_last;
		end
	end

	assign tx.valid = out_valid_q;
	assign tx.payload = out_q;
endmodule
